[rtl/tvst_pkg.sv]
package tvst_pkg;

	localparam int NUM_VOICES = 3;
	localparam int PERIOD_W   = 6;
	localparam int IDX_W      = 2;
	localparam int VALUE_W    = 8;
	localparam int SAMPLE_W   = 15;
	localparam int WEIGHT_LSB = 13;
	localparam int COUNT_W    = 2;

	localparam logic                CMD_WRITE  = 1'b0;
	localparam logic                CMD_TICK   = 1'b1;
	localparam logic [PERIOD_W-1:0] PERIOD_MAX = 6'h3f;

	typedef struct packed {
		logic wr;
		logic tick;
	} voice_ctrl_t;

endpackage

[rtl/tvst_req_if.sv]
interface tvst_req_if;
	import tvst_pkg::*;

	logic               valid;
	logic               ready;
	logic               cmd;
	logic [IDX_W-1:0]   voice_index;
	logic [VALUE_W-1:0] period_value;

	modport source (output valid, output cmd, output voice_index, output period_value,
		input ready);
	modport sink (input valid, input cmd, input voice_index, input period_value,
		output ready);
endinterface

[rtl/tvst_rsp_if.sv]
interface tvst_rsp_if;
	import tvst_pkg::*;

	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

[rtl/tvst_voice.sv]
module tvst_voice (
	input  logic                           clk,
	input  logic                           arst_n,
	input  tvst_pkg::voice_ctrl_t          ctrl,
	input  logic [tvst_pkg::PERIOD_W-1:0]  period_value,
	output logic                           sounding
);
	import tvst_pkg::*;

	logic [PERIOD_W-1:0] period_q;
	logic [PERIOD_W-1:0] counter_q;
	logic                level_q;
	logic [PERIOD_W-1:0] divisor;
	logic [PERIOD_W:0]   next_count;
	logic                wrap;

	assign divisor    = PERIOD_MAX - period_q;
	assign next_count = {1'b0, counter_q} + 1'b1;
	// A lowered divisor may already sit below the counter, so compare as reached or passed.
	assign wrap       = next_count >= {1'b0, divisor};
	assign sounding   = level_q && (divisor != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q  <= '0;
			counter_q <= '0;
			level_q   <= 1'b0;
		end else begin
			if (ctrl.wr) begin
				period_q <= period_value;
			end
			if (ctrl.tick) begin
				if (wrap) begin
					counter_q <= '0;
					level_q   <= ~level_q;
				end else begin
					counter_q <= next_count[PERIOD_W-1:0];
				end
			end
		end
	end

	a_counter_below_max: assert property (@(posedge clk) disable iff (!arst_n)
		counter_q != PERIOD_MAX)
		else $error("voice counter reached the all-ones value");

	a_level_moves_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		!ctrl.tick |=> $stable(level_q) && $stable(counter_q))
		else $error("voice state changed without a tick");

endmodule

[rtl/three_voice_square_tone_generator_unit.sv]
// A tick accepted on req passes stage one, then the output register, to reach rsp.
// Throughput: one item (write or tick) per cycle unless a tick stalls in stage one on a
// full output register; the stages let a new item enter while a finished sample waits.
// A write gives no sample and advances even while the output register is full.
// Reset (arst_n low, asynchronous) clears all periods, counters, levels and valid bits.
module three_voice_square_tone_generator_unit (
	input  logic       clk,
	input  logic       arst_n,
	tvst_req_if.sink   req,
	tvst_rsp_if.source rsp
);
	import tvst_pkg::*;

	logic                 valid_s1;
	logic                 cmd_s1;
	logic [IDX_W-1:0]     voice_index_s1;
	logic [PERIOD_W-1:0]  period_s1;
	logic                 out_valid_q;
	logic [SAMPLE_W-1:0]  sample_q;
	logic                 advance;
	logic                 tick_adv;
	logic [NUM_VOICES-1:0] sounding;
	logic [COUNT_W-1:0]   active;

	// A tick may only leave stage one when the output register is free or being drained.
	assign advance  = valid_s1 && ((cmd_s1 == CMD_WRITE) || !out_valid_q || rsp.ready);
	assign tick_adv = advance && (cmd_s1 == CMD_TICK);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			cmd_s1         <= req.cmd;
			voice_index_s1 <= req.voice_index;
			period_s1      <= req.period_value[PERIOD_W-1:0];
		end
	end

	genvar v;
	generate
		for (v = 0; v < NUM_VOICES; v++) begin : g_voice
			voice_ctrl_t ctrl;

			assign ctrl.wr   = advance && (cmd_s1 == CMD_WRITE)
				&& (voice_index_s1 == IDX_W'(v));
			assign ctrl.tick = tick_adv;

			tvst_voice u_voice (
				.clk          (clk),
				.arst_n       (arst_n),
				.ctrl         (ctrl),
				.period_value (period_s1),
				.sounding     (sounding[v])
			);
		end
	endgenerate

	assign active = COUNT_W'(sounding[0]) + COUNT_W'(sounding[1]) + COUNT_W'(sounding[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (tick_adv) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_adv) begin
			sample_q <= {active, {WEIGHT_LSB{1'b0}}};
		end
	end

	assign rsp.valid  = out_valid_q;
	assign rsp.sample = sample_q;

	a_stall_only_on_full_output: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> valid_s1 && out_valid_q && (cmd_s1 == CMD_TICK))
		else $error("input stalled while the output register could take a sample");

	a_result_from_tick: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(tick_adv))
		else $error("a sample appeared without a tick transfer");

	a_sample_weighted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (sample_q[WEIGHT_LSB-1:0] == '0)
		&& (sample_q[SAMPLE_W-1:WEIGHT_LSB] != 2'b11 || sample_q == 15'd24576))
		else $error("sample is not a whole number of voice levels");

endmodule

[dv/tvst_sample_checker.sv]
`timescale 1ns / 1ps

module tvst_sample_checker (
	input  logic clk,
	input  logic arst_n,
	tvst_req_if  req,
	tvst_rsp_if  rsp,
	output int   fail_count,
	output int   samples_pending
);
	import tvst_pkg::*;

	localparam logic [SAMPLE_W-1:0] LEVEL_WEIGHT = SAMPLE_W'(1) << WEIGHT_LSB;

	logic [PERIOD_W-1:0] period_q [NUM_VOICES];
	logic [PERIOD_W-1:0] count_q  [NUM_VOICES];
	logic                level_q  [NUM_VOICES];
	logic [SAMPLE_W-1:0] expected_samples [$];
	int                  mismatches = 0;

	assign fail_count = mismatches;

	always @(posedge clk or negedge arst_n) begin : predict
		logic [PERIOD_W-1:0] divisor;
		logic [PERIOD_W:0]   next_count;
		logic [SAMPLE_W-1:0] mix;
		logic [SAMPLE_W-1:0] expected;
		if (!arst_n) begin
			for (int v = 0; v < NUM_VOICES; v++) begin
				period_q[v] = '0;
				count_q[v]  = '0;
				level_q[v]  = 1'b0;
			end
			expected_samples.delete();
			samples_pending <= 0;
		end else begin
			// A sample leaves only after its tick has passed stage one and the output register, so
			// the response side is handled first without losing ordering.
			if (rsp.valid && rsp.ready) begin
				if (expected_samples.size() == 0) begin
					$display("%0t: unexpected sample: expected none, actual %0d",
						$time, rsp.sample);
					mismatches++;
				end else begin
					expected = expected_samples.pop_front();
					if (rsp.sample !== expected) begin
						$display("%0t: sample mismatch: expected %0d, actual %0d",
							$time, expected, rsp.sample);
						mismatches++;
					end
				end
			end
			if (req.valid && req.ready) begin
				if (req.cmd == CMD_WRITE) begin
					if (req.voice_index < NUM_VOICES)
						period_q[req.voice_index] = req.period_value[PERIOD_W-1:0];
				end else begin
					mix = '0;
					for (int v = 0; v < NUM_VOICES; v++) begin
						divisor = PERIOD_MAX - period_q[v];
						// A voice with a zero divisor is muted but keeps toggling.
						if (divisor != '0 && level_q[v])
							mix = mix + LEVEL_WEIGHT;
						next_count = {1'b0, count_q[v]} + 1'b1;
						if (next_count >= {1'b0, divisor}) begin
							count_q[v] = '0;
							level_q[v] = ~level_q[v];
						end else begin
							count_q[v] = next_count[PERIOD_W-1:0];
						end
					end
					expected_samples.push_back(mix);
				end
			end
			samples_pending <= expected_samples.size();
		end
	end

endmodule

[dv/three_voice_square_tone_generator_unit_tb.sv]
`timescale 1ns / 1ps

module three_voice_square_tone_generator_unit_tb;
	import tvst_pkg::*;

	localparam int IDLE_PCT     = 17;
	localparam int RANDOM_ITEMS = 800;
	localparam int STALL_LIMIT  = 1000;

	logic clk;
	logic arst_n;
	logic calm = 1'b0;
	int   fail_count;
	int   samples_pending;
	int   quiet_cycles = 0;

	tvst_req_if req ();
	tvst_rsp_if rsp ();

	three_voice_square_tone_generator_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	tvst_sample_checker sample_chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.req             (req),
		.rsp             (rsp),
		.fail_count      (fail_count),
		.samples_pending (samples_pending)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Any transfer on either channel counts as progress.
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			rsp.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	task automatic send_item(input logic c, input logic [IDX_W-1:0] idx,
		input logic [VALUE_W-1:0] val);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid        <= 1'b1;
		req.cmd          <= c;
		req.voice_index  <= idx;
		req.period_value <= val;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
	endtask

	task automatic wait_for_samples();
		req.valid <= 1'b0;
		@(posedge clk);
		while (samples_pending != 0)
			@(posedge clk);
	endtask

	initial begin
		logic [IDX_W-1:0]   idx;
		logic [VALUE_W-1:0] val;
		arst_n           <= 1'b0;
		req.valid        <= 1'b0;
		req.cmd          <= CMD_TICK;
		req.voice_index  <= '0;
		req.period_value <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Muted voice, slowest voice with upper bits set, fastest voice, ignored index.
		send_item(CMD_WRITE, 2'd0, 8'hff);
		send_item(CMD_WRITE, 2'd1, 8'hc0);
		send_item(CMD_WRITE, 2'd2, 8'h3e);
		send_item(CMD_WRITE, 2'd3, 8'h7f);
		send_item(CMD_TICK, 2'd3, 8'hff);
		send_item(CMD_TICK, 2'd0, 8'h00);
		send_item(CMD_TICK, 2'($urandom), 8'($urandom));
		send_item(CMD_TICK, 2'($urandom), 8'($urandom));
		// Voice 1 has counted past the new divisor, so it wraps on the next tick.
		send_item(CMD_WRITE, 2'd1, 8'h3d);
		send_item(CMD_TICK, 2'd1, 8'h55);
		send_item(CMD_TICK, 2'd2, 8'haa);
		send_item(CMD_TICK, 2'($urandom), 8'($urandom));
		send_item(CMD_WRITE, 2'd2, 8'h00);
		send_item(CMD_WRITE, 2'd0, 8'h3c);
		send_item(CMD_TICK, 2'($urandom), 8'($urandom));
		send_item(CMD_TICK, 2'($urandom), 8'($urandom));
		send_item(CMD_TICK, 2'($urandom), 8'($urandom));
		send_item(CMD_WRITE, 2'd0, 8'h3e);
		send_item(CMD_WRITE, 2'd1, 8'h3e);
		send_item(CMD_WRITE, 2'd2, 8'h7e);
		send_item(CMD_TICK, 2'($urandom), 8'($urandom));
		send_item(CMD_TICK, 2'($urandom), 8'($urandom));
		send_item(CMD_TICK, 2'($urandom), 8'($urandom));
		wait_for_samples();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == 200)
				calm <= 1'b1;
			if (i == 400) begin
				calm <= 1'b0;
				wait_for_samples();
			end
			if ($urandom_range(99) < 25) begin
				idx = IDX_W'($urandom_range(3));
				// Short periods are favored so that the voices toggle often.
				if ($urandom_range(1))
					val = 8'($urandom);
				else
					val = {2'($urandom), 6'($urandom_range(56, 63))};
				send_item(CMD_WRITE, idx, val);
			end else begin
				send_item(CMD_TICK, 2'($urandom), 8'($urandom));
			end
		end

		wait_for_samples();
		repeat (4) @(posedge clk);
		if (fail_count == 0 && samples_pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
